### rtl/core/atrd_pkg.sv
// ----------------------------------------------------------------------------
// atrd_pkg: shared types and constants of the AT response deframer
// Command format between parser and emitter, character codes, header and
// keyword tables.
// ----------------------------------------------------------------------------
package atrd_pkg;

    localparam int HDR_LEN   = 5;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam int N_KW      = 5;

    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_TEXT    = 1'b1;

    localparam logic [2:0] CLS_NONE   = 3'd0;
    localparam logic [2:0] CLS_OTHER  = 3'd1;
    localparam logic [2:0] CLS_KW_BASE = 3'd2;   // OK, ERROR, FAIL, ready, CLOSED follow

    // plain: one beat as given; replay: header prefix of cnt bytes
    typedef enum logic {
        OP_PLAIN  = 1'b0,
        OP_REPLAY = 1'b1
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       kind;
        logic       last;
        logic [2:0] cls;
        logic [2:0] cnt;
    } t_cmd;

    // "+IPD,"
    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CHAR_PLUS;
            3'd1:    c = 8'h49;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h44;
            3'd4:    c = 8'h2C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // keyword lengths: OK, ERROR, FAIL, ready, CLOSED
    function automatic logic [2:0] kw_len(input logic [2:0] k);
        logic [2:0] n;
        case (k)
            3'd0:    n = 3'd2;
            3'd1:    n = 3'd5;
            3'd2:    n = 3'd4;
            3'd3:    n = 3'd5;
            3'd4:    n = 3'd6;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            3'd0: begin
                case (pos)
                    3'd0:    c = 8'h4F;  // O
                    3'd1:    c = 8'h4B;  // K
                    default: c = 8'h00;
                endcase
            end
            3'd1: begin
                case (pos)
                    3'd0:    c = 8'h45;  // E
                    3'd1:    c = 8'h52;  // R
                    3'd2:    c = 8'h52;  // R
                    3'd3:    c = 8'h4F;  // O
                    3'd4:    c = 8'h52;  // R
                    default: c = 8'h00;
                endcase
            end
            3'd2: begin
                case (pos)
                    3'd0:    c = 8'h46;  // F
                    3'd1:    c = 8'h41;  // A
                    3'd2:    c = 8'h49;  // I
                    3'd3:    c = 8'h4C;  // L
                    default: c = 8'h00;
                endcase
            end
            3'd3: begin
                case (pos)
                    3'd0:    c = 8'h72;  // r
                    3'd1:    c = 8'h65;  // e
                    3'd2:    c = 8'h61;  // a
                    3'd3:    c = 8'h64;  // d
                    3'd4:    c = 8'h79;  // y
                    default: c = 8'h00;
                endcase
            end
            3'd4: begin
                case (pos)
                    3'd0:    c = 8'h43;  // C
                    3'd1:    c = 8'h4C;  // L
                    3'd2:    c = 8'h4F;  // O
                    3'd3:    c = 8'h53;  // S
                    3'd4:    c = 8'h45;  // E
                    3'd5:    c = 8'h44;  // D
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // drop keywords that no longer match after byte b at position pos
    function automatic logic [N_KW-1:0] kw_update(input logic [N_KW-1:0] cands,
                                                  input logic [2:0] pos,
                                                  input logic [7:0] b);
        logic [N_KW-1:0] r;
        r = cands;
        for (int k = 0; k < N_KW; k++) begin
            if (pos >= kw_len(3'(k)) || kw_char(3'(k), pos) != b) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    // class of a finished line; lowest keyword index wins
    function automatic logic [2:0] kw_class(input logic [N_KW-1:0] cands,
                                            input logic [2:0] pos);
        logic [2:0] c;
        c = CLS_OTHER;
        for (int k = N_KW - 1; k >= 0; k--) begin
            if (cands[k] && pos == kw_len(3'(k))) begin
                c = CLS_KW_BASE + 3'(k);
            end
        end
        return c;
    endfunction

endpackage

### rtl/core/at_response_deframer.sv
// ----------------------------------------------------------------------------
// at_response_deframer: modem byte stream to frames and response lines
// Parser, command queue and beat emitter.
// ----------------------------------------------------------------------------
// One received byte per input beat. "+IPD,<len>:" lines become payload beats
// (kind 0, last on the final byte); other lines come out as text beats
// (kind 1) one byte behind, with the byte before CR/LF marked last and
// carrying the line class (1 other, 2 OK, 3 ERROR, 4 FAIL, 5 ready,
// 6 CLOSED). A byte is taken every cycle while the 4-entry command queue has
// room. Each byte yields at most one command; a command is one output beat,
// except a replayed broken header, which takes one beat per held header byte
// (up to 4 held bytes). A queued command is loaded into the output register
// before it shows up as an output beat. Output beats sit in a register behind
// the queue, so under output stall the input keeps flowing until four
// commands wait. No reset sweep.
// ----------------------------------------------------------------------------
module at_response_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_kind,
    output logic       o_out_last,
    output logic [2:0] o_line_class
);
    import atrd_pkg::*;

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    // stall whenever the queue cannot take a command
    assign o_in_stall = q_full;

    atrd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    atrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_cmd)
    );

    atrd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_head     (head_cmd),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_out_kind   (o_out_kind),
        .o_out_last   (o_out_last),
        .o_line_class (o_line_class)
    );

endmodule

### rtl/core/atrd_front.sv
// ----------------------------------------------------------------------------
// atrd_front: byte parser
// Tracks line/header/length/payload phase and turns each byte into at most
// one emit command for the queue.
// ----------------------------------------------------------------------------
module atrd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_q_full,
    output logic           o_push,
    output atrd_pkg::t_cmd o_cmd
);
    import atrd_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_TEXT    = 5'b00010,
        PH_HEADER  = 5'b00100,
        PH_LENGTH  = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    t_phase          r_phase,  n_phase;
    logic [2:0]      r_fill,   n_fill;
    logic [15:0]     r_len,    n_len;
    logic [15:0]     r_rem,    n_rem;
    logic [7:0]      r_held,   n_held;
    logic            r_hv,     n_hv;
    logic [N_KW-1:0] r_cands,  n_cands;
    logic [2:0]      r_pos,    n_pos;

    logic            accept;
    logic            eol;
    logic [2:0]      pos_inc;

    assign accept  = i_in_valid && !i_q_full;
    assign eol     = (i_rx_byte == CHAR_CR) || (i_rx_byte == CHAR_LF);
    assign pos_inc = (r_pos < 3'd7) ? r_pos + 3'd1 : 3'd7;

    always_comb begin
        n_phase = r_phase;
        n_fill  = r_fill;
        n_len   = r_len;
        n_rem   = r_rem;
        n_held  = r_held;
        n_hv    = r_hv;
        n_cands = r_cands;
        n_pos   = r_pos;
        o_push  = 1'b0;
        o_cmd   = '0;
        if (accept) begin
            case (r_phase)
                PH_TEXT: begin
                    if (eol) begin
                        o_push      = r_hv;
                        o_cmd.op    = OP_PLAIN;
                        o_cmd.data  = r_held;
                        o_cmd.kind  = KIND_TEXT;
                        o_cmd.last  = 1'b1;
                        o_cmd.cls   = kw_class(r_cands, r_pos);
                        n_hv        = 1'b0;
                        n_cands     = '1;
                        n_pos       = 3'd0;
                        n_fill      = 3'd0;
                        n_phase     = PH_IDLE;
                    end else begin
                        o_push      = r_hv;
                        o_cmd.op    = OP_PLAIN;
                        o_cmd.data  = r_held;
                        o_cmd.kind  = KIND_TEXT;
                        o_cmd.cls   = CLS_NONE;
                        n_held      = i_rx_byte;
                        n_hv        = 1'b1;
                        n_cands     = kw_update(r_cands, r_pos, i_rx_byte);
                        n_pos       = pos_inc;
                    end
                end
                PH_HEADER: begin
                    if (eol) begin
                        // held prefix goes out as a whole line of class other
                        o_push      = 1'b1;
                        o_cmd.op    = OP_REPLAY;
                        o_cmd.kind  = KIND_TEXT;
                        o_cmd.last  = 1'b1;
                        o_cmd.cls   = CLS_OTHER;
                        o_cmd.cnt   = r_fill;
                        n_hv        = 1'b0;
                        n_cands     = '1;
                        n_pos       = 3'd0;
                        n_fill      = 3'd0;
                        n_phase     = PH_IDLE;
                    end else if (i_rx_byte == hdr_char(r_fill)) begin
                        if (r_fill == 3'(HDR_LEN - 1)) begin
                            n_fill  = 3'd0;
                            n_len   = '0;
                            n_phase = PH_LENGTH;
                        end else begin
                            n_fill  = r_fill + 3'd1;
                        end
                    end else begin
                        // broken header: prefix becomes text; '+' kills every keyword
                        o_push      = 1'b1;
                        o_cmd.op    = OP_REPLAY;
                        o_cmd.kind  = KIND_TEXT;
                        o_cmd.cls   = CLS_NONE;
                        o_cmd.cnt   = r_fill;
                        n_held      = i_rx_byte;
                        n_hv        = 1'b1;
                        n_cands     = '0;
                        n_pos       = r_fill + 3'd1;
                        n_fill      = 3'd0;
                        n_phase     = PH_TEXT;
                    end
                end
                PH_LENGTH: begin
                    if (i_rx_byte == CHAR_COLON) begin
                        n_rem   = r_len;
                        n_phase = (r_len == '0) ? PH_IDLE : PH_PAYLOAD;
                    end else begin
                        n_len = {r_len[12:0], 3'b000} + {r_len[14:0], 1'b0}
                              + {8'h00, i_rx_byte} - {8'h00, CHAR_ZERO};
                    end
                end
                PH_PAYLOAD: begin
                    o_push      = 1'b1;
                    o_cmd.op    = OP_PLAIN;
                    o_cmd.data  = i_rx_byte;
                    o_cmd.kind  = KIND_PAYLOAD;
                    o_cmd.last  = (r_rem == 16'd1);
                    o_cmd.cls   = CLS_NONE;
                    n_rem       = r_rem - 16'd1;
                    if (r_rem == 16'd1) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    // idle between lines
                    if (eol) begin
                        n_phase = PH_IDLE;
                    end else if (i_rx_byte == CHAR_PLUS) begin
                        n_cands = '1;
                        n_pos   = 3'd0;
                        n_fill  = 3'd1;
                        n_phase = PH_HEADER;
                    end else begin
                        n_held  = i_rx_byte;
                        n_hv    = 1'b1;
                        n_cands = kw_update('1, 3'd0, i_rx_byte);
                        n_pos   = 3'd1;
                        n_phase = PH_TEXT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_fill  <= '0;
            r_len   <= '0;
            r_rem   <= '0;
            r_held  <= '0;
            r_hv    <= 1'b0;
            r_cands <= '1;
            r_pos   <= '0;
        end else begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_len   <= n_len;
            r_rem   <= n_rem;
            r_held  <= n_held;
            r_hv    <= n_hv;
            r_cands <= n_cands;
            r_pos   <= n_pos;
        end
    end

endmodule

### rtl/core/atrd_queue.sv
// ----------------------------------------------------------------------------
// atrd_queue: command queue
// Small FIFO between parser and emitter.
// ----------------------------------------------------------------------------
module atrd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  atrd_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output atrd_pkg::t_cmd o_head
);
    import atrd_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/core/atrd_back.sv
// ----------------------------------------------------------------------------
// atrd_back: beat emitter
// Expands queued commands into output beats and holds them in an output
// register.
// ----------------------------------------------------------------------------
module atrd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  atrd_pkg::t_cmd i_q_head,
    output logic           o_pop,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic [7:0]     o_out_byte,
    output logic           o_out_kind,
    output logic           o_out_last,
    output logic [2:0]     o_line_class
);
    import atrd_pkg::*;

    logic [1:0] r_sub;       // beat index inside a replay
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_kind;
    logic       r_last;
    logic [2:0] r_cls;

    logic       load;
    logic       fire;
    logic       final_beat;
    logic [7:0] e_byte;
    logic       e_last;
    logic [2:0] e_cls;

    assign load       = !r_valid || !i_out_stall;
    assign fire       = i_q_valid && load;
    assign final_beat = (i_q_head.op == OP_PLAIN)
                     || ({1'b0, r_sub} + 3'd1 == i_q_head.cnt);
    assign o_pop      = fire && final_beat;

    always_comb begin
        if (i_q_head.op == OP_REPLAY) begin
            e_byte = hdr_char({1'b0, r_sub});
            e_last = i_q_head.last && final_beat;
            e_cls  = final_beat ? i_q_head.cls : CLS_NONE;
        end else begin
            e_byte = i_q_head.data;
            e_last = i_q_head.last;
            e_cls  = i_q_head.cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_byte <= e_byte;
            r_kind <= i_q_head.kind;
            r_last <= e_last;
            r_cls  <= e_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= '0;
        end else begin
            if (load) begin
                r_valid <= fire;
            end
            if (fire) begin
                r_sub <= final_beat ? 2'd0 : r_sub + 2'd1;
            end
        end
    end

    assign o_out_valid  = r_valid;
    assign o_out_byte   = r_byte;
    assign o_out_kind   = r_kind;
    assign o_out_last   = r_last;
    assign o_line_class = r_cls;

endmodule
